// File: src/lmqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmqs_pkg: shared types and constants for the quarter-scan LED driver
// Request kinds, colour codes, pin levels and the stage-two control word.
// ----------------------------------------------------------------------------
package lmqs_pkg;

  localparam int PANEL_COLS_DEF = 64;
  localparam int SCAN_ROWS      = 4;
  localparam int SCAN_W         = 2;
  localparam int HALF_ROW_W     = 3;
  localparam int CODE_W         = 3;
  localparam int RGB_W          = 3;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 16;

  typedef enum logic [0:0] {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

  localparam logic [CODE_W-1:0] CODE_OFF   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_GB    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_RED   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_RB    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_GREEN = 3'd4;

  localparam logic [RGB_W-1:0] RGB_OFF   = 3'b000;
  localparam logic [RGB_W-1:0] RGB_GB    = 3'b011;
  localparam logic [RGB_W-1:0] RGB_RED   = 3'b100;
  localparam logic [RGB_W-1:0] RGB_RB    = 3'b101;
  localparam logic [RGB_W-1:0] RGB_GREEN = 3'b010;

  typedef struct packed {
    logic              tick;
    logic              rd;
    logic              col_ok;
    logic              latch;
    logic              oe;
    logic              clk;
    logic [SCAN_W-1:0] rsel;
  } lmqs_s2_t;

  function automatic logic [RGB_W-1:0] code_to_rgb(input logic [CODE_W-1:0] code,
                                                    input logic [RGB_W-1:0] old);
    logic [RGB_W-1:0] res;
    case (code)
      CODE_OFF:   res = RGB_OFF;
      CODE_GB:    res = RGB_GB;
      CODE_RED:   res = RGB_RED;
      CODE_RB:    res = RGB_RB;
      CODE_GREEN: res = RGB_GREEN;
      default:    res = old;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/led_matrix_quarter_scan_driver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_quarter_scan_driver_top: quarter-scan RGB LED panel driver
// Frame store of 3-bit colour codes, shift clock, data, latch, row and OE pins.
// ----------------------------------------------------------------------------
// Input stream: tuser 0 is a timer tick, 1 writes one pixel code (row, column,
// code in tdata). Every item gives one result item with the pin levels after
// it: shift clock, upper and lower RGB, row select, latch pulse and OE.
// The result passes the input register, the frame store read and the pin
// register. Throughput: one item per cycle while m_tready is high; the frame
// store has one read port per panel half, so each high-phase tick reads both
// halves in the same cycle.
// Reset: pins, shift clock, pixel count and scan row go to zero, then a
// clearing sweep zeroes the frame store, during which s_tready stays low.
// Stall: while m_tready is low the result holds and up to two more items are
// taken into the internal stages before s_tready drops.
// ----------------------------------------------------------------------------
module led_matrix_quarter_scan_driver_top #(
  parameter int PANEL_COLS = lmqs_pkg::PANEL_COLS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // pixel_row[3:0], pixel_col[9:4], pixel_code[12:10], zero fill
  input  wire logic [lmqs_pkg::IN_TDATA_W-1:0]  s_tdata,
  // req_type[0]
  input  wire logic                             s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // shift_clk[0], upper_rgb[3:1], lower_rgb[6:4], row_select[8:7],
  // latch_pulse[9], output_disable[10], zero fill
  output      logic [lmqs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import lmqs_pkg::*;

  localparam int COL_W = $clog2(PANEL_COLS);
  localparam int AW    = HALF_ROW_W + COL_W;
  localparam int DEPTH = 2 ** AW;

  logic              s2_en;
  logic              s2_load;
  lmqs_s2_t          s2_info;
  logic              we_upper;
  logic              we_lower;
  logic [AW-1:0]     waddr;
  logic [CODE_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic              clearing;
  logic [CODE_W-1:0] rdata_upper;
  logic [CODE_W-1:0] rdata_lower;

  lmqs_scan_ctrl #(
    .PANEL_COLS (PANEL_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s2_en    (s2_en),
    .s2_load  (s2_load),
    .s2_info  (s2_info),
    .we_upper (we_upper),
    .we_lower (we_lower),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .clearing (clearing)
  );

  lmqs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram_upper (
    .clk   (clk),
    .we    (we_upper),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_upper)
  );

  lmqs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram_lower (
    .clk   (clk),
    .we    (we_lower),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_lower)
  );

  lmqs_pixel_out u_out (
    .clk         (clk),
    .rst         (rst),
    .s2_load     (s2_load),
    .s2_info     (s2_info),
    .rdata_upper (rdata_upper),
    .rdata_lower (rdata_lower),
    .s2_en       (s2_en),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

`ifndef SYNTH
  // a latched line restarts the count, so OE must be low
  a_latch_oe_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> !m_tdata[10])
    else $error("latch pulse with OE high");

  // latching happens only on a high-phase tick
  a_latch_clk_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[0])
    else $error("latch pulse with shift clock low");

  // no item taken and no result shown while the frame store is cleared
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> clearing && !s_tready && !m_tvalid)
    else $error("activity during clearing sweep");
`endif

endmodule
`default_nettype wire

// File: src/lmqs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmqs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmqs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/lmqs_scan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmqs_scan_ctrl: input stage and scan sequencing
// Holds the input item, tracks shift clock, pixel count and scan row, drives
// the frame store ports and runs the clearing sweep after reset.
// ----------------------------------------------------------------------------
module lmqs_scan_ctrl #(
  parameter int PANEL_COLS = 64,
  localparam int COL_W = $clog2(PANEL_COLS),
  localparam int AW    = lmqs_pkg::HALF_ROW_W + COL_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  input  wire logic [lmqs_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire logic                                s_tuser,
  input  wire logic                                s2_en,
  output      logic                                s2_load,
  output      lmqs_pkg::lmqs_s2_t                  s2_info,
  output      logic                                we_upper,
  output      logic                                we_lower,
  output      logic [AW-1:0]                       waddr,
  output      logic [lmqs_pkg::CODE_W-1:0]         wdata,
  output      logic                                re,
  output      logic [AW-1:0]                       raddr,
  output      logic                                clearing
);
  import lmqs_pkg::*;

  localparam int CNT_W = COL_W + 1;
  localparam int LINE_PIXELS = 2 * PANEL_COLS;
  localparam logic [CNT_W-1:0] LAST_PIXEL = CNT_W'(LINE_PIXELS - 1);

  logic [AW-1:0]     clr_addr;
  logic              s1_valid;
  req_t              s1_type;
  logic [3:0]        s1_row;
  logic [5:0]        s1_col;
  logic [CODE_W-1:0] s1_code;
  logic              clock_level;
  logic [CNT_W-1:0]  pixel_count;
  logic [SCAN_W-1:0] scan_row;

  logic              tick;
  logic              clk_new;
  logic              rd;
  logic              latch;
  logic [COL_W-1:0]  rd_col;
  logic              col_ok;
  logic              wr_ok;
  logic [CNT_W-1:0]  pixel_count_next;
  logic [SCAN_W-1:0] scan_row_next;

  assign s_tready = !clearing && (!s1_valid || s2_en);
  assign s2_load  = s1_valid && s2_en;

  assign tick    = (s1_type == REQ_TICK);
  assign clk_new = ~clock_level;
  assign rd      = tick && clk_new;
  assign latch   = rd && (pixel_count == LAST_PIXEL);
  assign rd_col  = {pixel_count[CNT_W-1:3], pixel_count[1:0]};
  assign col_ok  = 32'(rd_col) < 32'(PANEL_COLS);
  assign wr_ok   = 32'(s1_col) < 32'(PANEL_COLS);

  always_comb begin
    pixel_count_next = pixel_count;
    scan_row_next    = scan_row;
    if (latch) begin
      pixel_count_next = '0;
      scan_row_next    = scan_row + 1'b1;
    end else if (rd) begin
      pixel_count_next = pixel_count + 1'b1;
    end
  end

  // upper half holds rows 0..7, lower half rows 8..15
  assign raddr    = {~pixel_count[2], scan_row, rd_col};
  assign re       = s2_load && rd;
  assign we_upper = clearing || (s2_load && !tick && wr_ok && !s1_row[3]);
  assign we_lower = clearing || (s2_load && !tick && wr_ok && s1_row[3]);
  assign waddr    = clearing ? clr_addr : {s1_row[2:0], COL_W'(s1_col)};
  assign wdata    = clearing ? CODE_OFF : s1_code;

  always_comb begin
    s2_info.tick   = tick;
    s2_info.rd     = rd;
    s2_info.col_ok = col_ok;
    s2_info.latch  = latch;
    s2_info.oe     = (pixel_count_next[1:0] != 2'b00);
    s2_info.clk    = tick ? clk_new : clock_level;
    s2_info.rsel   = scan_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      clock_level <= 1'b0;
      pixel_count <= '0;
      scan_row    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (s_tvalid && s_tready) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load && tick) begin
        clock_level <= clk_new;
        pixel_count <= pixel_count_next;
        scan_row    <= scan_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_type <= req_t'(s_tuser);
      s1_row  <= s_tdata[3:0];
      s1_col  <= s_tdata[9:4];
      s1_code <= s_tdata[12:10];
    end
  end

endmodule
`default_nettype wire

// File: src/lmqs_pixel_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmqs_pixel_out: colour decode and pin register
// Takes the frame store read data, maps colour codes to pin levels and holds
// the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lmqs_pixel_out (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s2_load,
  input  wire lmqs_pkg::lmqs_s2_t               s2_info,
  input  wire logic [lmqs_pkg::CODE_W-1:0]      rdata_upper,
  input  wire logic [lmqs_pkg::CODE_W-1:0]      rdata_lower,
  output      logic                             s2_en,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [lmqs_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import lmqs_pkg::*;

  logic              s2_valid;
  lmqs_s2_t          s2;
  logic              out_en;
  logic              shift_clk;
  logic [RGB_W-1:0]  upper_rgb;
  logic [RGB_W-1:0]  lower_rgb;
  logic [SCAN_W-1:0] row_select;
  logic              latch_pulse;
  logic              output_disable;
  logic [CODE_W-1:0] code_u;
  logic [CODE_W-1:0] code_l;

  assign out_en = !m_tvalid || m_tready;
  assign s2_en  = !s2_valid || out_en;
  assign code_u = s2.col_ok ? rdata_upper : CODE_OFF;
  assign code_l = s2.col_ok ? rdata_lower : CODE_OFF;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2 <= s2_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      shift_clk      <= 1'b0;
      upper_rgb      <= '0;
      lower_rgb      <= '0;
      row_select     <= '0;
      latch_pulse    <= 1'b0;
      output_disable <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_en) begin
        s2_valid <= 1'b0;
      end
      if (out_en) begin
        m_tvalid <= s2_valid;
        if (s2_valid) begin
          shift_clk   <= s2.clk;
          latch_pulse <= s2.tick && s2.latch;
          if (s2.rd) begin
            upper_rgb <= code_to_rgb(code_u, upper_rgb);
            lower_rgb <= code_to_rgb(code_l, lower_rgb);
          end
          if (s2.tick) begin
            output_disable <= s2.oe;
          end
          if (s2.tick && s2.latch) begin
            row_select <= s2.rsel;
          end
        end
      end
    end
  end

  assign m_tdata = {5'd0, output_disable, latch_pulse, row_select,
                    lower_rgb, upper_rgb, shift_clk};

endmodule
`default_nettype wire
